[sv/erm_pkg.sv]
// Shared constants, stage types and fixed-point helpers for the Euler rotation matrix block.
// Used by erm_sincos and euler_rotation_matrix; depends on nothing else.
package erm_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int CELL_W       = 16;

    // CORDIC datapath: Q1.30 on x and y, 32-bit turn on z
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int TRIG_SHIFT = CORDIC_FRAC - FRAC_BITS;
    localparam int TRIG_HALF  = (1 << TRIG_SHIFT) >> 1;
    localparam int FRAC_HALF  = (1 << FRAC_BITS) >> 1;

    localparam int TRIG_W  = FRAC_BITS + 2;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int PRODX_W = PROD_W + 1;
    localparam int RND_W   = TRIG_W + 1;
    localparam int QPROD_W = RND_W + TRIG_W;
    localparam int SUM_W   = QPROD_W + 1;

    localparam int TRIG_LATENCY  = CORDIC_STEPS + 1;
    localparam int MATRIX_STAGES = 5;
    localparam int PIPE_DEPTH    = TRIG_LATENCY + MATRIX_STAGES;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

    // atan(2^-i), 2^32 is one full turn
    localparam logic signed [CORDIC_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
        32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
        32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic [1:0]                 quad;
    } cordic_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } trig_t;

    // One micro-rotation; the sign of the residual angle picks the direction
    function automatic cordic_t cordic_step(input cordic_t s, input logic [STEP_IDX_W-1:0] k);
        cordic_t r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        r  = s;
        dx = s.y >>> k;
        dy = s.x >>> k;
        if (!s.z[CORDIC_W-1])
        begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - ATAN_TURN[k];
        end
        else
        begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + ATAN_TURN[k];
        end
        return r;
    endfunction

    function automatic logic signed [TRIG_W-1:0] round_trig(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        t = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(TRIG_HALF);
        t = t >>> TRIG_SHIFT;
        return TRIG_W'(t);
    endfunction

    // Fold the first-quadrant result back to the full turn, then round
    function automatic trig_t map_quadrant(input cordic_t s);
        trig_t r;
        logic signed [CORDIC_W-1:0] c;
        logic signed [CORDIC_W-1:0] sn;
        case (s.quad)
            QUAD_0:
            begin
                c  = s.x;
                sn = s.y;
            end
            QUAD_1:
            begin
                c  = -s.y;
                sn = s.x;
            end
            QUAD_2:
            begin
                c  = -s.x;
                sn = -s.y;
            end
            default:
            begin
                c  = s.y;
                sn = -s.x;
            end
        endcase
        r.cos_val = round_trig(c);
        r.sin_val = round_trig(sn);
        return r;
    endfunction

    // Round a product back to FRAC_BITS fraction bits, half up
    function automatic logic signed [RND_W-1:0] fix_prod(input logic signed [PRODX_W-1:0] v);
        logic signed [PRODX_W-1:0] t;
        t = (v + PRODX_W'(FRAC_HALF)) >>> FRAC_BITS;
        return RND_W'(t);
    endfunction

    function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [SUM_W-1:0] v);
        logic signed [CELL_W-1:0] r;
        if (v > SUM_W'(CELL_MAX))
            r = CELL_MAX;
        else if (v < SUM_W'(CELL_MIN))
            r = CELL_MIN;
        else
            r = CELL_W'(v);
        return r;
    endfunction

    function automatic logic signed [CELL_W-1:0] fix_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v + SUM_W'(FRAC_HALF)) >>> FRAC_BITS;
        return sat_cell(t);
    endfunction

endpackage

[sv/euler_rotation_matrix.sv]
// Top level of the Euler x-y-z rotation matrix block: three CORDIC sine units and the
// product pipeline for the nine 3x3 entries. Depends on erm_pkg and erm_sincos.

// Takes one triple of binary angles (65536 is one full turn) per beat and returns the nine
// entries of the 3x3 rotation block in signed Q2.14, rounded half up and clamped to 16 bits.
// Accepts a new triple every clock cycle while in_stall is low; each triple passes through
// 30 CORDIC steps plus a quadrant/rounding stage in each sine unit, then five
// stages of products, rounding, second products, sums and final round-and-clamp. The
// output register is the last stage. While a result waits with out_stall high the whole
// pipeline holds and in_stall is raised; nothing is dropped or repeated. Reset clears only
// the valid bits.
module euler_rotation_matrix (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [erm_pkg::ANGLE_WIDTH-1:0]        angle_x,
    input  logic [erm_pkg::ANGLE_WIDTH-1:0]        angle_y,
    input  logic [erm_pkg::ANGLE_WIDTH-1:0]        angle_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_00,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_01,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_02,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_10,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_11,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_12,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_20,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_21,
    output logic signed [erm_pkg::CELL_W-1:0]      cell_22
);
    import erm_pkg::*;

    // Stage 1: products of the rounded cosines and sines, with three factors carried along
    typedef struct packed {
        logic signed [TRIG_W-1:0] cx;
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cz;
        logic signed [PROD_W-1:0] cycz;
        logic signed [PROD_W-1:0] sxsy;
        logic signed [PROD_W-1:0] cxsz;
        logic signed [PROD_W-1:0] sycx;
        logic signed [PROD_W-1:0] sxsz;
        logic signed [PROD_W-1:0] szcy;
        logic signed [PROD_W-1:0] szsx;
        logic signed [PROD_W-1:0] cxcz;
        logic signed [PROD_W-1:0] szsy;
        logic signed [PROD_W-1:0] sxcz;
        logic signed [PROD_W-1:0] sxcy;
        logic signed [PROD_W-1:0] cxcy;
    } s1_t;

    // Fixed entries, finished early and carried to the output
    typedef struct packed {
        logic signed [CELL_W-1:0] c00;
        logic signed [CELL_W-1:0] c10;
        logic signed [CELL_W-1:0] c20;
        logic signed [CELL_W-1:0] c21;
        logic signed [CELL_W-1:0] c22;
    } early_t;

    // Stage 2: rounded first products of the three-factor terms
    typedef struct packed {
        logic signed [TRIG_W-1:0] cx;
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cz;
        logic signed [RND_W-1:0]  r_sxsy;
        logic signed [RND_W-1:0]  r_nsycx;
        logic signed [RND_W-1:0]  r_nszsx;
        logic signed [RND_W-1:0]  r_szsy;
        logic signed [PROD_W-1:0] cxsz;
        logic signed [PROD_W-1:0] sxsz;
        logic signed [PROD_W-1:0] cxcz;
        logic signed [PROD_W-1:0] sxcz;
        early_t                   early;
    } s2_t;

    // Stage 3: second products
    typedef struct packed {
        logic signed [QPROD_W-1:0] q01;
        logic signed [QPROD_W-1:0] q02;
        logic signed [QPROD_W-1:0] q11;
        logic signed [QPROD_W-1:0] q12;
        logic signed [PROD_W-1:0]  cxsz;
        logic signed [PROD_W-1:0]  sxsz;
        logic signed [PROD_W-1:0]  cxcz;
        logic signed [PROD_W-1:0]  sxcz;
        early_t                    early;
    } s3_t;

    // Stage 4: exact sums
    typedef struct packed {
        logic signed [SUM_W-1:0] s01;
        logic signed [SUM_W-1:0] s02;
        logic signed [SUM_W-1:0] s11;
        logic signed [SUM_W-1:0] s12;
        early_t                  early;
    } s4_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] c00;
        logic signed [CELL_W-1:0] c01;
        logic signed [CELL_W-1:0] c02;
        logic signed [CELL_W-1:0] c10;
        logic signed [CELL_W-1:0] c11;
        logic signed [CELL_W-1:0] c12;
        logic signed [CELL_W-1:0] c20;
        logic signed [CELL_W-1:0] c21;
        logic signed [CELL_W-1:0] c22;
    } out_t;

    logic                  advance;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] valid_reg;
    trig_t                 trig_x;
    trig_t                 trig_y;
    trig_t                 trig_z;
    s1_t                   s1_next;
    s1_t                   s1_reg;
    s2_t                   s2_next;
    s2_t                   s2_reg;
    s3_t                   s3_next;
    s3_t                   s3_reg;
    s4_t                   s4_next;
    s4_t                   s4_reg;
    out_t                  out_next;
    out_t                  out_reg;

    // Hold every stage only when a finished beat is waiting and the sink stalls
    assign advance  = !(valid_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall = !advance;

    erm_sincos u_sincos_x (
        .clk   (clk),
        .en    (advance),
        .angle (angle_x),
        .trig  (trig_x)
    );

    erm_sincos u_sincos_y (
        .clk   (clk),
        .en    (advance),
        .angle (angle_y),
        .trig  (trig_y)
    );

    erm_sincos u_sincos_z (
        .clk   (clk),
        .en    (advance),
        .angle (angle_z),
        .trig  (trig_z)
    );

    // Stage 1: twelve products, one multiplier each
    always_comb
    begin
        s1_next.cx   = trig_x.cos_val;
        s1_next.sy   = trig_y.sin_val;
        s1_next.cz   = trig_z.cos_val;
        s1_next.cycz = trig_y.cos_val * trig_z.cos_val;
        s1_next.sxsy = trig_x.sin_val * trig_y.sin_val;
        s1_next.cxsz = trig_x.cos_val * trig_z.sin_val;
        s1_next.sycx = trig_y.sin_val * trig_x.cos_val;
        s1_next.sxsz = trig_x.sin_val * trig_z.sin_val;
        s1_next.szcy = trig_z.sin_val * trig_y.cos_val;
        s1_next.szsx = trig_z.sin_val * trig_x.sin_val;
        s1_next.cxcz = trig_x.cos_val * trig_z.cos_val;
        s1_next.szsy = trig_z.sin_val * trig_y.sin_val;
        s1_next.sxcz = trig_x.sin_val * trig_z.cos_val;
        s1_next.sxcy = trig_x.sin_val * trig_y.cos_val;
        s1_next.cxcy = trig_x.cos_val * trig_y.cos_val;
    end

    // Stage 2: round the inner products; negate before rounding, as half-up is not symmetric.
    // The single-product entries are finished here.
    always_comb
    begin
        s2_next.cx        = s1_reg.cx;
        s2_next.sy        = s1_reg.sy;
        s2_next.cz        = s1_reg.cz;
        s2_next.r_sxsy    = fix_prod(PRODX_W'(s1_reg.sxsy));
        s2_next.r_nsycx   = fix_prod(-PRODX_W'(s1_reg.sycx));
        s2_next.r_nszsx   = fix_prod(-PRODX_W'(s1_reg.szsx));
        s2_next.r_szsy    = fix_prod(PRODX_W'(s1_reg.szsy));
        s2_next.cxsz      = s1_reg.cxsz;
        s2_next.sxsz      = s1_reg.sxsz;
        s2_next.cxcz      = s1_reg.cxcz;
        s2_next.sxcz      = s1_reg.sxcz;
        s2_next.early.c00 = fix_sat(SUM_W'(s1_reg.cycz));
        s2_next.early.c10 = fix_sat(-SUM_W'(s1_reg.szcy));
        s2_next.early.c20 = sat_cell(SUM_W'(s1_reg.sy));
        s2_next.early.c21 = fix_sat(-SUM_W'(s1_reg.sxcy));
        s2_next.early.c22 = fix_sat(SUM_W'(s1_reg.cxcy));
    end

    // Stage 3: rounded product times the third factor
    always_comb
    begin
        s3_next.q01   = s2_reg.r_sxsy * s2_reg.cz;
        s3_next.q02   = s2_reg.r_nsycx * s2_reg.cz;
        s3_next.q11   = s2_reg.r_nszsx * s2_reg.sy;
        s3_next.q12   = s2_reg.r_szsy * s2_reg.cx;
        s3_next.cxsz  = s2_reg.cxsz;
        s3_next.sxsz  = s2_reg.sxsz;
        s3_next.cxcz  = s2_reg.cxcz;
        s3_next.sxcz  = s2_reg.sxcz;
        s3_next.early = s2_reg.early;
    end

    // Stage 4: exact sums, rounded only once at the end
    always_comb
    begin
        s4_next.s01   = SUM_W'(s3_reg.q01) + SUM_W'(s3_reg.cxsz);
        s4_next.s02   = SUM_W'(s3_reg.q02) + SUM_W'(s3_reg.sxsz);
        s4_next.s11   = SUM_W'(s3_reg.q11) + SUM_W'(s3_reg.cxcz);
        s4_next.s12   = SUM_W'(s3_reg.q12) + SUM_W'(s3_reg.sxcz);
        s4_next.early = s3_reg.early;
    end

    // Stage 5: round, clamp and load the output register
    always_comb
    begin
        out_next.c00 = s4_reg.early.c00;
        out_next.c01 = fix_sat(s4_reg.s01);
        out_next.c02 = fix_sat(s4_reg.s02);
        out_next.c10 = s4_reg.early.c10;
        out_next.c11 = fix_sat(s4_reg.s11);
        out_next.c12 = fix_sat(s4_reg.s12);
        out_next.c20 = s4_reg.early.c20;
        out_next.c21 = s4_reg.early.c21;
        out_next.c22 = s4_reg.early.c22;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            out_reg <= out_next;
        end
    end

    // Valid bits travel alongside the data; when advancing, in_stall is low so in_valid
    // marks exactly an accepted beat
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign cell_00   = out_reg.c00;
    assign cell_01   = out_reg.c01;
    assign cell_02   = out_reg.c02;
    assign cell_10   = out_reg.c10;
    assign cell_11   = out_reg.c11;
    assign cell_12   = out_reg.c12;
    assign cell_20   = out_reg.c20;
    assign cell_21   = out_reg.c21;
    assign cell_22   = out_reg.c22;

endmodule

[sv/erm_sincos.sv]
// Pipelined CORDIC giving cosine and sine of one binary angle, one angle per cycle while en is high.
// Depends on erm_pkg for the step, quadrant and rounding helpers.
module erm_sincos (
    input  logic                          clk,
    input  logic                          en,
    input  logic [erm_pkg::ANGLE_WIDTH-1:0] angle,
    output erm_pkg::trig_t                trig
);
    import erm_pkg::*;

    logic [CORDIC_W-1:0] turn;
    cordic_t             init;
    cordic_t             stage_next [CORDIC_STEPS];
    cordic_t             stage_reg  [CORDIC_STEPS];
    trig_t               trig_next;
    trig_t               trig_reg;

    // Scale to a 32-bit turn; the top two bits pick the quadrant
    always_comb
    begin
        turn      = {angle, (CORDIC_W-ANGLE_WIDTH)'(0)};
        init.x    = CORDIC_GAIN;
        init.y    = '0;
        init.z    = {2'b00, turn[CORDIC_W-3:0]};
        init.quad = turn[CORDIC_W-1 -: 2];
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign stage_next[k] = cordic_step(init, STEP_IDX_W'(k));
        end
        else
        begin : g_rest
            assign stage_next[k] = cordic_step(stage_reg[k-1], STEP_IDX_W'(k));
        end
    end

    assign trig_next = map_quadrant(stage_reg[CORDIC_STEPS-1]);

    // Advance all stages together; hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
            trig_reg  <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

[verif/tb.sv]
// Self-checking bench for euler_rotation_matrix: directed angle triples, then random ones.
// It predicts each 3x3 rotation block with its own CORDIC and fixed-point model.
// Depends on erm_pkg (widths and quadrant codes) and the RTL top level only.
module tb;

    // Bit-true predictor settings: Q1.30 CORDIC, cells in Q2.14
    localparam int     Q_FRAC       = 14;
    localparam int     ROT_FRAC     = 30;
    localparam int     ROT_STEPS    = 30;
    localparam longint ROT_GAIN     = 64'd652032874;
    localparam int     PIPE_LATENCY = 36;
    localparam int     RANDOM_PER_PHASE = 338;
    localparam int     NUM_PHASES   = 4;

    // atan(2^-i) in a 32-bit turn
    localparam longint ATAN_STEP [ROT_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    // Nine cells of one rotation block; element k is cell_<k/3><k%3>
    typedef logic [8:0][erm_pkg::CELL_W-1:0] matrix_t;

    localparam logic [erm_pkg::CELL_W-1:0] Q_ONE  = 16'd16384;
    localparam logic [erm_pkg::CELL_W-1:0] Q_ZERO = 16'd0;
    // Symmetric in the flattened index, so the order of the concatenation does not matter
    localparam matrix_t IDENTITY_MAT = {Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
                                        Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE};

    typedef struct packed {
        logic [erm_pkg::ANGLE_WIDTH-1:0] ax;
        logic [erm_pkg::ANGLE_WIDTH-1:0] ay;
        logic [erm_pkg::ANGLE_WIDTH-1:0] az;
        logic                            is_identity;
    } angle_row_t;

    // Directed triples. Rows flagged as identity carry their answer: no rotation at all,
    // and a half turn about every axis, which folds back to the identity.
    // Every other row goes through the predictor.
    localparam int NUM_DIRECTED = 22;
    localparam angle_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1},
        '{16'h8000, 16'h8000, 16'h8000, 1'b1},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
        '{16'h4000, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 16'h4000, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'h4000, 1'b0},
        '{16'hC000, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 16'hC000, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'hC000, 1'b0},
        '{16'h4000, 16'h4000, 16'h4000, 1'b0},
        '{16'hC000, 16'hC000, 16'hC000, 1'b0},
        '{16'h4000, 16'h4000, 16'h0000, 1'b0},
        '{16'hC000, 16'h4000, 16'hC000, 1'b0},
        '{16'h2000, 16'h2000, 16'h2000, 1'b0},
        '{16'hE000, 16'h6000, 16'hA000, 1'b0},
        '{16'h0001, 16'h7FFF, 16'h8001, 1'b0},
        '{16'h3FFF, 16'h4001, 16'hBFFF, 1'b0},
        '{16'hC001, 16'hFFFE, 16'h0002, 1'b0},
        '{16'h5555, 16'hAAAA, 16'h5555, 1'b0},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0},
        '{16'h1234, 16'h89AB, 16'hCDEF, 1'b0},
        '{16'h6000, 16'h2000, 16'hE000, 1'b0}
    };

    // Idling per phase, in percent: none, sender only, receiver only, both
    localparam int IDLE_PCT  [NUM_PHASES] = '{0, 57, 0, 14};
    localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 57, 14};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic [erm_pkg::ANGLE_WIDTH-1:0] angle_x = '0;
    logic [erm_pkg::ANGLE_WIDTH-1:0] angle_y = '0;
    logic [erm_pkg::ANGLE_WIDTH-1:0] angle_z = '0;
    logic in_stall;
    logic out_valid;
    logic signed [erm_pkg::CELL_W-1:0] cell_00, cell_01, cell_02;
    logic signed [erm_pkg::CELL_W-1:0] cell_10, cell_11, cell_12;
    logic signed [erm_pkg::CELL_W-1:0] cell_20, cell_21, cell_22;

    matrix_t pending_matrices [$];
    int      mismatch_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;

    euler_rotation_matrix u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_00   (cell_00),
        .cell_01   (cell_01),
        .cell_02   (cell_02),
        .cell_10   (cell_10),
        .cell_11   (cell_11),
        .cell_12   (cell_12),
        .cell_20   (cell_20),
        .cell_21   (cell_21),
        .cell_22   (cell_22)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round half up: floor((v + half) / 2^sh); >>> on a signed longint floors
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [erm_pkg::CELL_W-1:0] clamp_cell(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[erm_pkg::CELL_W-1:0];
    endfunction

    // Cosine and sine of a binary angle: rotate the in-quadrant part, then fold by quadrant
    function automatic void sincos_fixed(input logic [erm_pkg::ANGLE_WIDTH-1:0] ang,
                                         output longint cos_q, output longint sin_q);
        logic [31:0] turn;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, c, s;
        turn = 32'(ang) << (32 - erm_pkg::ANGLE_WIDTH);
        quad = turn[31:30];
        x = ROT_GAIN;
        y = 0;
        z = longint'(turn[29:0]);
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        case (quad)
            erm_pkg::QUAD_0:
            begin
                c = x;
                s = y;
            end
            erm_pkg::QUAD_1:
            begin
                c = -y;
                s = x;
            end
            erm_pkg::QUAD_2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
        cos_q = round_half_up(c, ROT_FRAC - Q_FRAC);
        sin_q = round_half_up(s, ROT_FRAC - Q_FRAC);
    endfunction

    // Nine cells of the x-y-z rotation block; inner products are rounded once before
    // the second multiply, each sum is rounded once at the end, then clamped
    function automatic matrix_t predict_rotation(input logic [erm_pkg::ANGLE_WIDTH-1:0] ax,
                                                 input logic [erm_pkg::ANGLE_WIDTH-1:0] ay,
                                                 input logic [erm_pkg::ANGLE_WIDTH-1:0] az);
        longint  cx, sx, cy, sy, cz, sz;
        matrix_t m;
        sincos_fixed(ax, cx, sx);
        sincos_fixed(ay, cy, sy);
        sincos_fixed(az, cz, sz);
        m[0] = clamp_cell(round_half_up(cy * cz, Q_FRAC));
        m[1] = clamp_cell(round_half_up(round_half_up(sx * sy, Q_FRAC) * cz + cx * sz,
                                        Q_FRAC));
        m[2] = clamp_cell(round_half_up(round_half_up(-sy * cx, Q_FRAC) * cz + sx * sz,
                                        Q_FRAC));
        m[3] = clamp_cell(round_half_up(-sz * cy, Q_FRAC));
        m[4] = clamp_cell(round_half_up(round_half_up(-sz * sx, Q_FRAC) * sy + cx * cz,
                                        Q_FRAC));
        m[5] = clamp_cell(round_half_up(round_half_up(sz * sy, Q_FRAC) * cx + sx * cz,
                                        Q_FRAC));
        m[6] = clamp_cell(sy);
        m[7] = clamp_cell(round_half_up(-sx * cy, Q_FRAC));
        m[8] = clamp_cell(round_half_up(cx * cy, Q_FRAC));
        return m;
    endfunction

    // Mostly uniform angles; one in five sits within a few steps of a quadrant boundary
    function automatic logic [erm_pkg::ANGLE_WIDTH-1:0] pick_angle();
        if ($urandom_range(4) == 0)
            return {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(8)) - 16'd4;
        return 16'($urandom);
    endfunction

    // Present one triple and hold it until the block takes the beat. Acceptance is judged
    // from values sampled at the falling edge, which stay put until the next rising edge.
    // The expected block is queued once the beat has gone in.
    task automatic send_triple(input logic [erm_pkg::ANGLE_WIDTH-1:0] ax,
                               input logic [erm_pkg::ANGLE_WIDTH-1:0] ay,
                               input logic [erm_pkg::ANGLE_WIDTH-1:0] az,
                               input matrix_t want);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle_x  <= ax;
        angle_y  <= ay;
        angle_z  <= az;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_valid && !in_stall;
            @(posedge clk);
        end
        pending_matrices.push_back(want);
    endtask

    // Drop valid and hold off until every queued block has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_matrices.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall at random at the rate of the current phase
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Result checker: sample at the falling edge, compare once the beat is taken
    initial
    begin
        bit      got;
        matrix_t seen;
        matrix_t want;
        forever
        begin
            @(negedge clk);
            got  = rst_n && out_valid && !out_stall;
            seen = {cell_22, cell_21, cell_20, cell_12, cell_11, cell_10,
                    cell_02, cell_01, cell_00};
            @(posedge clk);
            if (got)
            begin
                if (pending_matrices.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = pending_matrices.pop_front();
                    for (int k = 0; k < 9; k++)
                    begin
                        if (seen[k] !== want[k])
                        begin
                            mismatch_count++;
                            $display("%0t: cell_%0d%0d expected %0d got %0d", $time,
                                     k / 3, k % 3, $signed(want[k]), $signed(seen[k]));
                        end
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, then one random stretch per idling phase with a
    // full drain in between, so the sender pauses until the pipeline is empty
    initial
    begin
        logic [erm_pkg::ANGLE_WIDTH-1:0] ax, ay, az;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r])
        begin
            ax = DIRECTED_ROWS[r].ax;
            ay = DIRECTED_ROWS[r].ay;
            az = DIRECTED_ROWS[r].az;
            send_triple(ax, ay, az, DIRECTED_ROWS[r].is_identity ? IDENTITY_MAT
                                                                 : predict_rotation(ax, ay, az));
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                ax = pick_angle();
                ay = pick_angle();
                az = pick_angle();
                send_triple(ax, ay, az, predict_rotation(ax, ay, az));
            end
        end

        // Wait out the pipeline, then a little more to catch any stray result beat
        drain_results();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_matrices.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
